// ===== hw/rtl/sgks_pkg.sv =====
// Shared constants and types of the servo gait keyframe sequencer.
package sgks_pkg;

    localparam int MaxEntries = 16;
    localparam int IdxW       = 4;
    localparam int FracBits   = 10;
    localparam int PeriodW    = 24;
    localparam int QW         = 11;
    localparam int TimeW      = 48;
    localparam int DegW       = 8;
    localparam int CntW       = 5;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 24;
    localparam int EntryW     = 2 + 3 * QW;
    // Widths of the time-window arithmetic.
    localparam int PW         = PeriodW + FracBits;
    localparam int WinW       = PeriodW + QW + 1;
    localparam int ProdW      = QW + 1 + WinW;
    localparam int DivCntW    = 6;

    localparam logic [CfgIdxW-1:0] CfgPeriod    = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgAmplitude = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgMaxDeg    = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgCount     = 2'd3;

    localparam logic FuncTick = 1'b0;
    localparam logic FuncLoad = 1'b1;

    typedef struct packed {
        logic [1:0]    motor;
        logic [QW-1:0] target;
        logic [QW-1:0] start;
        logic [QW-1:0] duration;
    } t_entry;

    typedef struct packed {
        logic                func;
        logic [PeriodW-1:0]  delta_us;
        logic [IdxW-1:0]     entry_index;
        logic [1:0]          entry_motor;
        logic [QW-1:0]       entry_target;
        logic [QW-1:0]       entry_start;
        logic [QW-1:0]       entry_duration;
    } t_in;

    typedef struct packed {
        logic [DegW-1:0]  left_degrees;
        logic [DegW-1:0]  right_degrees;
        logic [DegW-1:0]  tail_degrees;
        logic [TimeW-1:0] elapsed_us;
    } t_out;

endpackage

// ===== hw/rtl/sgks_if.sv =====
// Valid/ready channel interfaces for the sequencer's input and output.
interface sgks_in_if;
    logic           valid;
    logic           ready;
    sgks_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sgks_out_if;
    logic           valid;
    logic           ready;
    sgks_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sgks_ram.sv =====
// Generic single-port RAM with registered read.
module sgks_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Read-first port: a read in a write cycle returns the old data; read data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/servo_gait_keyframe_sequencer.sv =====
// Top level of the servo gait keyframe sequencer.
//
//  channel   direction  payload
//  in_ch     sink       func, delta_us, entry fields
//  out_ch    source     three servo angles, elapsed_us
//  cfg       write      period, amplitude, max degrees, entry count
//
// A load writes its table entry, then converts the three positions to degrees.
// A tick advances phase and time, walks the used entries and, per active entry,
// runs the shift-add multiplier, the bit-serial restoring divider and an apply
// step; the degree conversion, one motor at a time, follows the walk.
// Reset is synchronous and clears control state, phase, time and positions.
// A result waits in the output register; the next item is taken after it.
module servo_gait_keyframe_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sgks_in_if.sink                          in_ch,
    sgks_out_if.source                       out_ch,
    input  logic                             i_cfg_we,
    input  logic [sgks_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [sgks_pkg::CfgDataW-1:0]    i_cfg_data
);
    localparam int PW    = sgks_pkg::PW;
    localparam int WinW  = sgks_pkg::WinW;
    localparam int ProdW = sgks_pkg::ProdW;
    localparam int QW    = sgks_pkg::QW;

    typedef enum logic [3:0] {
        S_IDLE, S_PHASE, S_WRAP, S_RD, S_RDW, S_EVAL, S_MUL, S_DIV, S_APPLY,
        S_NEXT, S_DEG, S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [sgks_pkg::PeriodW-1:0] r_period;
    logic [QW-1:0]                r_amp;
    logic [sgks_pkg::DegW-1:0]    r_maxdeg;
    logic [sgks_pkg::CntW-1:0]    r_count;

    // Block state.
    logic [sgks_pkg::PeriodW-1:0] r_phase;
    logic                         r_phc;
    logic [sgks_pkg::TimeW-1:0]   r_total;
    logic [QW-1:0]                r_pos [3];
    logic [QW-1:0]                r_scr [3];

    // Work registers.
    sgks_pkg::t_in                r_item;
    logic [sgks_pkg::IdxW:0]      r_idx;
    logic [sgks_pkg::IdxW:0]      r_lim;
    logic [1:0]                   r_m;
    logic                         r_neg;
    logic [QW-1:0]                r_base;
    logic [ProdW-1:0]             r_mcand;   // multiplicand, shifted left
    logic [QW:0]                  r_mplier;  // multiplier, shifted right
    logic [ProdW-1:0]             r_acc;
    logic [ProdW-1:0]             r_quo;     // dividend shifting into quotient
    logic [WinW:0]                r_rem;
    logic [WinW-1:0]              r_den;
    logic [sgks_pkg::DivCntW-1:0] r_cnt;
    logic [1:0]                   r_dsel;
    logic [sgks_pkg::DegW-1:0]    r_deg [3];
    logic                         r_ovalid;

    // Table memory, one entry per slot.
    logic                         ram_we;
    logic [sgks_pkg::IdxW-1:0]    ram_addr;
    sgks_pkg::t_entry             ram_wdata;
    logic [sgks_pkg::EntryW-1:0]  ram_rdata;
    sgks_pkg::t_entry             ent;

    sgks_ram #(.Width(sgks_pkg::EntryW), .Depth(sgks_pkg::MaxEntries)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign ent       = sgks_pkg::t_entry'(ram_rdata);
    assign ram_we    = (r_state == S_PHASE) && (r_item.func == sgks_pkg::FuncLoad);
    assign ram_addr  = (r_state == S_PHASE) ? r_item.entry_index
                                            : r_idx[sgks_pkg::IdxW-1:0];
    assign ram_wdata = '{motor: r_item.entry_motor, target: r_item.entry_target,
                         start: r_item.entry_start, duration: r_item.entry_duration};

    // Window evaluation of the current entry.
    logic [PW-1:0]    p_val;
    logic [WinW-1:0]  s_val, e_val;
    logic             active;
    logic [QW:0]      goal;
    logic [QW+QW-1:0] gprod;
    logic [QW-1:0]    scr_m;
    logic [1:0]       em;

    assign em     = ent.motor - 2'd1;
    assign p_val  = {r_phase, {sgks_pkg::FracBits{1'b0}}};
    assign s_val  = WinW'(ent.start) * WinW'(r_period);
    assign e_val  = WinW'(WinW'(ent.start) + WinW'(ent.duration)) * WinW'(r_period);
    assign active = (WinW'(p_val) >= s_val) && (WinW'(p_val) < e_val);
    assign gprod  = (QW+QW)'(ent.target) * (QW+QW)'(r_amp);
    assign goal   = gprod[sgks_pkg::FracBits +: QW+1];
    assign scr_m  = r_scr[em];

    // Divider trial subtraction and result.
    logic [WinW:0]   rem_sh;
    logic            rem_ge;
    logic [ProdW:0]  pos_sum;
    assign rem_sh  = {r_rem[WinW-1:0], r_quo[ProdW-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_den};
    assign pos_sum = r_neg ? ((ProdW+1)'(r_base) - (ProdW+1)'(r_quo))
                           : ((ProdW+1)'(r_base) + (ProdW+1)'(r_quo));

    // Tick arithmetic.
    logic [sgks_pkg::PeriodW-1:0] d_clamp;
    logic [sgks_pkg::PeriodW:0]   ph_sum;
    logic [sgks_pkg::TimeW:0]     t_sum;
    assign d_clamp = (r_item.delta_us < r_period) ? r_item.delta_us : r_period;
    assign ph_sum  = {1'b0, r_phase} + {1'b0, d_clamp};
    assign t_sum   = {1'b0, r_total} + (sgks_pkg::TimeW+1)'(r_item.delta_us);

    // Degree conversion, one motor at a time, shift-add over 8 bits.
    logic [QW+sgks_pkg::DegW-1:0] dg_prod;
    logic [QW-1:0]                pos_d;
    assign pos_d = r_pos[r_dsel];

    assign in_ch.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = '{left_degrees: r_deg[0], right_degrees: r_deg[1],
                            tail_degrees: r_deg[2], elapsed_us: r_total};

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_period <= sgks_pkg::PeriodW'(2000000);
            r_amp    <= QW'(1024);
            r_maxdeg <= sgks_pkg::DegW'(90);
            r_count  <= '0;
            r_phase  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_deg[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sgks_pkg::CfgPeriod:    r_period <= i_cfg_data;
                    sgks_pkg::CfgAmplitude: r_amp    <= i_cfg_data[QW-1:0];
                    sgks_pkg::CfgMaxDeg:    r_maxdeg <= i_cfg_data[sgks_pkg::DegW-1:0];
                    sgks_pkg::CfgCount:     r_count  <= i_cfg_data[sgks_pkg::CntW-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_item  <= in_ch.data;
                        r_state <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    // Loads write the table in this cycle.
                    if (r_item.func == sgks_pkg::FuncLoad) begin
                        r_dsel  <= 2'd0;
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_state <= S_DEG;
                    end else begin
                        r_phase <= ph_sum[sgks_pkg::PeriodW-1:0];
                        r_phc   <= ph_sum[sgks_pkg::PeriodW];
                        r_total <= t_sum[sgks_pkg::TimeW] ? '1
                                                          : t_sum[sgks_pkg::TimeW-1:0];
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    // The sum keeps its carry, so a single wrap lands in range while the phase was below the period.
                    if ({r_phc, r_phase} >= {1'b0, r_period}) begin
                        r_phase <= r_phase - r_period;
                    end
                    r_idx <= '0;
                    r_lim <= (r_count > sgks_pkg::CntW'(sgks_pkg::MaxEntries))
                             ? (sgks_pkg::IdxW+1)'(sgks_pkg::MaxEntries)
                             : r_count;
                    for (int k = 0; k < 3; k++) r_scr[k] <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_idx >= r_lim) begin
                        r_dsel  <= 2'd0;
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_state <= S_DEG;
                    end else begin
                        r_state <= S_RDW;
                    end
                end
                S_RDW: r_state <= S_EVAL;
                S_EVAL: begin
                    r_m <= em;
                    if (ent.motor == 2'd0) begin
                        r_state <= S_NEXT;
                    end else if (!active) begin
                        r_scr[em] <= ent.target;
                        r_state   <= S_NEXT;
                    end else begin
                        r_base   <= scr_m;
                        r_neg    <= goal < {1'b0, scr_m};
                        r_mplier <= (goal >= {1'b0, scr_m}) ? goal - {1'b0, scr_m}
                                                            : {1'b0, scr_m} - goal;
                        r_mcand  <= ProdW'(WinW'(p_val) - s_val);
                        r_den    <= e_val - s_val;
                        r_acc    <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    // Shift-add multiply, one multiplier bit per cycle.
                    if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == sgks_pkg::DivCntW'(QW)) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (r_cnt == '0) begin
                        r_quo <= r_acc;
                        r_rem <= '0;
                        r_cnt <= 1'b1;
                    end else begin
                        r_rem <= rem_ge ? rem_sh - {1'b0, r_den} : rem_sh;
                        r_quo <= {r_quo[ProdW-2:0], rem_ge};
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == sgks_pkg::DivCntW'(ProdW)) r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_pos[r_m] <= (!r_neg && (pos_sum > (ProdW+1)'(2047))) ? QW'(2047)
                                  : pos_sum[QW-1:0];
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_RD;
                end
                S_DEG: begin
                    // Shift-add of max degrees by position, one bit per cycle.
                    if (r_cnt == sgks_pkg::DivCntW'(sgks_pkg::DegW)) begin
                        r_deg[r_dsel] <= (r_acc[QW+sgks_pkg::DegW-1:sgks_pkg::FracBits]
                                          > 9'd255) ? 8'd255
                                         : r_acc[sgks_pkg::FracBits +: sgks_pkg::DegW];
                        r_cnt <= '0;
                        r_acc <= '0;
                        if (r_dsel == 2'd2) r_state <= S_OUT;
                        r_dsel <= r_dsel + 1'b1;
                    end else begin
                        if (r_maxdeg[r_cnt[2:0]]) begin
                            r_acc <= r_acc + ProdW'(dg_prod);
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign dg_prod = (QW+sgks_pkg::DegW)'(pos_d) << r_cnt[2:0];
endmodule

// ===== test/servo_gait_keyframe_sequencer_test.sv =====
// Randomized self-checking testbench for the servo gait keyframe sequencer.
module servo_gait_keyframe_sequencer_test;
    import sgks_pkg::*;

    localparam int SettleCycles = 1000;

    // Gait state tracker: follows the table, phase and positions of the block
    // and holds the servo commands that each accepted transaction should yield.
    class gait_tracker;
        t_entry          table_q[MaxEntries];
        longint unsigned phase;
        longint unsigned elapsed;
        longint unsigned pos[3];
        longint unsigned period;
        longint unsigned gain;
        longint unsigned deg_full;
        longint unsigned count;
        t_out            awaited[$];
        int              fails;

        function new();
            phase    = 0;
            elapsed  = 0;
            pos      = '{0, 0, 0};
            period   = 2000000;
            gain     = 1024;
            deg_full = 90;
            count    = 0;
            fails    = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, longint unsigned val);
            case (idx)
                CfgPeriod:    period   = val & 24'hFFFFFF;
                CfgAmplitude: gain     = val & 11'h7FF;
                CfgMaxDeg:    deg_full = val & 8'hFF;
                CfgCount:     count    = val & 5'h1F;
                default: ;
            endcase
        endfunction

        function logic [DegW-1:0] degrees(longint unsigned p);
            longint unsigned d;
            d = (p * deg_full) >> FracBits;
            return (d > 255) ? 8'd255 : d[DegW-1:0];
        endfunction

        // Walk the used entries and move each motor toward its amplified target.
        function void walk();
            longint unsigned scratch[3];
            longint unsigned n, p, s, e, goal, base, num, den, np;
            int m;
            scratch = '{0, 0, 0};
            n = (count > MaxEntries) ? MaxEntries : count;
            p = phase << FracBits;
            for (int i = 0; i < n; i++) begin
                if (table_q[i].motor == 0) continue;
                m = table_q[i].motor - 1;
                s = longint'(table_q[i].start) * period;
                e = (longint'(table_q[i].start) + table_q[i].duration) * period;
                if (p < s || p >= e) begin
                    scratch[m] = table_q[i].target;
                end else begin
                    goal = (longint'(table_q[i].target) * gain) >> FracBits;
                    base = scratch[m];
                    num  = p - s;
                    den  = e - s;
                    if (goal >= base) np = base + ((goal - base) * num) / den;
                    else np = base - ((base - goal) * num) / den;
                    pos[m] = (np > 2047) ? 2047 : np;
                end
            end
        endfunction

        function void note(t_in x);
            longint unsigned d, ph;
            t_out r;
            if (x.func == FuncLoad) begin
                table_q[x.entry_index] = '{x.entry_motor, x.entry_target,
                                           x.entry_start, x.entry_duration};
            end else begin
                d  = (x.delta_us < period) ? x.delta_us : period;
                ph = phase + d;
                if (ph >= period) ph -= period;
                phase = ph & 24'hFFFFFF;
                if (elapsed > 48'hFFFFFFFFFFFF - x.delta_us) elapsed = 48'hFFFFFFFFFFFF;
                else elapsed += x.delta_us;
                walk();
            end
            r.left_degrees  = degrees(pos[0]);
            r.right_degrees = degrees(pos[1]);
            r.tail_degrees  = degrees(pos[2]);
            r.elapsed_us    = elapsed[TimeW-1:0];
            awaited = {awaited, r};
        endfunction

        function void check(t_out got);
            t_out w;
            if (awaited.size() == 0) begin
                $error("result arrived with no transaction pending");
                fails++;
                return;
            end
            w = awaited.pop_front();
            if (got.left_degrees !== w.left_degrees) begin
                $error("left_degrees expected %0d got %0d", w.left_degrees, got.left_degrees);
                fails++;
            end
            if (got.right_degrees !== w.right_degrees) begin
                $error("right_degrees expected %0d got %0d", w.right_degrees,
                       got.right_degrees);
                fails++;
            end
            if (got.tail_degrees !== w.tail_degrees) begin
                $error("tail_degrees expected %0d got %0d", w.tail_degrees, got.tail_degrees);
                fails++;
            end
            if (got.elapsed_us !== w.elapsed_us) begin
                $error("elapsed_us expected %0d got %0d", w.elapsed_us, got.elapsed_us);
                fails++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    bit                  steady;
    gait_tracker         gait;

    sgks_in_if  in_ch ();
    sgks_out_if out_ch ();

    servo_gait_keyframe_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running clock with a period of two time units.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic bit pause_now();
        return !steady && ($urandom_range(0, 99) < 22);
    endfunction

    // Result side: check each accepted transaction, then stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) gait.check(out_ch.data);
        out_ch.ready <= !pause_now();
    end

    // Offer one input transaction, with random gaps ahead of it.
    task automatic send(t_in x);
        while (pause_now()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= x;
        do @(posedge i_clk); while (!in_ch.ready);
        gait.note(x);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (gait.awaited.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all four registers once the block has gone idle.
    task automatic configure(longint unsigned per, longint unsigned amp,
                             longint unsigned mdeg, longint unsigned cnt);
        longint unsigned vals[4];
        logic [CfgIdxW-1:0] regs[4];
        vals = '{per, amp, mdeg, cnt};
        regs = '{CfgPeriod, CfgAmplitude, CfgMaxDeg, CfgCount};
        drain();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[k];
            i_cfg_data <= CfgDataW'(vals[k]);
            @(posedge i_clk);
            gait.set_reg(regs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in load_item(int idx, int mot, int tgt, int st, int dur);
        t_in x;
        x = '0;
        x.func           = FuncLoad;
        x.delta_us       = PeriodW'($urandom());
        x.entry_index    = IdxW'(idx);
        x.entry_motor    = 2'(mot);
        x.entry_target   = QW'(tgt);
        x.entry_start    = QW'(st);
        x.entry_duration = QW'(dur);
        return x;
    endfunction

    function automatic t_in tick_item(longint unsigned dl);
        t_in x;
        x = '0;
        x.func           = FuncTick;
        x.delta_us       = PeriodW'(dl);
        x.entry_index    = IdxW'($urandom());
        x.entry_motor    = 2'($urandom());
        x.entry_target   = QW'($urandom());
        x.entry_start    = QW'($urandom());
        x.entry_duration = QW'($urandom());
        return x;
    endfunction

    // Mostly sensible windows and short ticks, with some raw noise mixed in.
    function automatic t_in random_item();
        int sel, st;
        longint unsigned per;
        per = (gait.period == 0) ? 1 : gait.period;
        sel = $urandom_range(0, 99);
        if (sel < 22) begin
            st = $urandom_range(0, 1023);
            return load_item($urandom_range(0, 15), $urandom_range(0, 3),
                             $urandom_range(0, 1024), st, $urandom_range(0, 1024 - st));
        end
        if (sel < 27)
            return load_item($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        if (sel < 70) return tick_item($urandom_range(0, per / 16 + 1));
        if (sel < 88) return tick_item($urandom_range(0, per));
        if (sel < 96) return tick_item($urandom() & 24'hFFFFFF);
        return tick_item(($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 0);
    endfunction

    initial begin
        gait         = new();
        steady       = 1'b0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CfgPeriod;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill every slot with extreme targets and windows, including
        // unused motors, a zero duration and windows as long as the whole period.
        for (int i = 0; i < MaxEntries; i++)
            send(load_item(i, i % 4, (i % 3 == 0) ? 2047 : ((i % 3 == 1) ? 0 : 1024),
                           (i * 64) % 1024, (i == 5) ? 0 : ((i % 2 != 0) ? 1024 : 200)));
        configure(1024, 2047, 255, 16);
        send(tick_item(0));
        send(tick_item(1));
        send(tick_item(512));
        send(tick_item(24'hFFFFFF));
        send(tick_item(300));

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: configure(1, 0, 0, 31);
                1: configure(24'hFFFFFF, 1024, 255, 16);
                2: configure(0, 1024, 90, 16);
                3: configure(2000000, 2047, 255, 0);
                4: configure(5000, 1024, 255, 16);
                default: configure($urandom_range(1, 20000), $urandom_range(0, 2047),
                                   $urandom_range(0, 255), $urandom_range(0, 31));
            endcase
            steady = (ph == 5);
            // In phase 7, lower the period under the current phase once.
            if (ph == 7) begin
                send(tick_item(gait.period - 1));
                configure(3, gait.gain, gait.deg_full, gait.count);
            end
            for (int n = 0; n < 135; n++) send(random_item());
        end
        steady = 1'b0;

        drain();
        repeat (SettleCycles) @(posedge i_clk);
        if (gait.fails == 0) begin
            $display("servo_gait_keyframe_sequencer test passed");
        end else begin
            $display("servo_gait_keyframe_sequencer test failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #40000000;
        $display("servo_gait_keyframe_sequencer test failed");
        $finish;
    end

endmodule
